[sv/rrq_pkg.sv]
// ---------------------------------------------------------------------------
// rrq_pkg - shared types and codes for the round-robin ready queue
// Slot state, request mode and status codes, and the control part of the
// token that walks the row of slot cells.
// ---------------------------------------------------------------------------
package rrq_pkg;

  localparam int IN_W  = 8;
  localparam int OUT_W = 8;

  // per-slot task state
  typedef logic [1:0] sstate_t;
  localparam sstate_t ST_UNUSED  = 2'd0;
  localparam sstate_t ST_READY   = 2'd1;
  localparam sstate_t ST_RUNNING = 2'd2;
  localparam sstate_t ST_BLOCKED = 2'd3;

  // request modes
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_CREATE = 3'd0;
  localparam mode_t MODE_TICK   = 3'd1;
  localparam mode_t MODE_BLOCK  = 3'd2;
  localparam mode_t MODE_WAKE   = 3'd3;
  localparam mode_t MODE_EXIT   = 3'd4;

  // result status
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_IGNORED = 2'd1;
  localparam status_t STAT_FULL    = 2'd2;

  // token commands
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PROBE  = 2'd0;  // read state and link of slot key
  localparam cmd_t CMD_APPEND = 2'd1;  // link slot val in behind tail (link == key)
  localparam cmd_t CMD_TICK   = 2'd2;  // key = head runs, val = old current yields
  localparam cmd_t CMD_UNLINK = 2'd3;  // drop slot key, predecessor takes val

  typedef struct packed {
    logic    valid;
    cmd_t    cmd;
    sstate_t ns;        // new state of slot key on unlink
    logic    flag;      // old current valid on tick
    sstate_t rd_state;  // probed state, collected on the way
  } tok_ctl_t;

endpackage

[sv/round_robin_ready_queue.sv]
// ---------------------------------------------------------------------------
// round_robin_ready_queue - round-robin task scheduler with a ready ring
// Slot states and ring links live in a row of cells; a sequencer sends a
// token down the row to probe, append, unlink or schedule a slot.
// ---------------------------------------------------------------------------
//  channel | dir | ports                            | request
//  in      | in  | in_tvalid in_tready in_tdata     | mode, task_index
//  out     | out | out_tvalid out_tready out_tdata  | result_task, result_valid, status
//
//  One request at a time. Each token pass walks the cell row one slot per
//  cycle. Create and tick take one pass; block, wake and exit probe first
//  and take a second pass when the probed state allows the request (exit
//  always does); requests rejected up front send no token.
//  A new request is taken while the previous result waits on out_tready.
//  After reset all slots are unused; no clearing pass is needed.
// ---------------------------------------------------------------------------
module round_robin_ready_queue #(
  parameter int MAX_TASKS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rrq_pkg::IN_W-1:0]  in_tdata,   // [2:0] mode, [6:3] task_index
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rrq_pkg::OUT_W-1:0] out_tdata   // [3:0] result_task, [4] result_valid,
                                                // [6:5] status
);
  import rrq_pkg::*;

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WPROBE = 2'd1;
  localparam logic [1:0] S_WACT   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]     state_r, state_nxt;
  mode_t          mode_r, mode_nxt;
  status_t        status_r, status_nxt;
  logic [SW-1:0]  t_r, t_nxt;
  sstate_t        pst_r, pst_nxt;
  logic [SW-1:0]  plink_r, plink_nxt;
  logic [SW-1:0]  head_r, head_nxt;
  logic           ring_ne_r, ring_ne_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic           cur_vld_r, cur_vld_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  tok_ctl_t       iss_ctl_r, iss_ctl_nxt;
  logic [SW-1:0]  iss_key_r, iss_key_nxt;
  logic [SW-1:0]  iss_val_r, iss_val_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // token row
  tok_ctl_t       ctl_w  [MAX_TASKS+1];
  logic [SW-1:0]  key_w  [MAX_TASKS+1];
  logic [SW-1:0]  val_w  [MAX_TASKS+1];
  logic [SW-1:0]  link_w [MAX_TASKS+1];
  logic [MAX_TASKS:0] tok_vld;

  mode_t          in_mode;
  logic [3:0]     in_idx;
  logic [SW-1:0]  in_slot;
  logic           idx_ok;
  tok_ctl_t       ret_ctl;
  logic [SW-1:0]  ret_link;
  logic           pst_in_ring;
  logic [3:0]     res_task;
  logic           res_vld;

  assign in_mode  = in_tdata[2:0];
  assign in_idx   = in_tdata[6:3];
  assign in_slot  = SW'(in_idx);
  assign idx_ok   = 32'(in_idx) < MAX_TASKS;
  assign ret_ctl  = ctl_w[MAX_TASKS];
  assign ret_link = link_w[MAX_TASKS];
  assign pst_in_ring = (pst_r == ST_READY) || (pst_r == ST_RUNNING);

  assign ctl_w[0]  = iss_ctl_r;
  assign key_w[0]  = iss_key_r;
  assign val_w[0]  = iss_val_r;
  assign link_w[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    rrq_cell #(
      .SW      (SW),
      .CELL_ID (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_w[g]),
      .key_i  (key_w[g]),
      .val_i  (val_w[g]),
      .link_i (link_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .key_o  (key_w[g+1]),
      .val_o  (val_w[g+1]),
      .link_o (link_w[g+1])
    );
  end

  for (genvar g = 0; g <= MAX_TASKS; g++) begin : g_vld
    assign tok_vld[g] = ctl_w[g].valid;
  end

  // result fields from the state after the request
  always_comb begin
    if (mode_r == MODE_CREATE) begin
      res_vld  = (status_r == STAT_OK);
      res_task = res_vld ? 4'(t_r) : 4'd0;
    end else begin
      res_vld  = cur_vld_r;
      res_task = cur_vld_r ? 4'(cur_r) : 4'd0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    status_nxt   = status_r;
    t_nxt        = t_r;
    pst_nxt      = pst_r;
    plink_nxt    = plink_r;
    head_nxt     = head_r;
    ring_ne_nxt  = ring_ne_r;
    cur_nxt      = cur_r;
    cur_vld_nxt  = cur_vld_r;
    count_nxt    = count_r;
    iss_ctl_nxt  = '0;
    iss_key_nxt  = iss_key_r;
    iss_val_nxt  = iss_val_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_mode;
          status_nxt = STAT_IGNORED;
          state_nxt  = S_DONE;
          case (in_mode)
            MODE_CREATE: begin
              if (count_r >= CW'(MAX_TASKS)) begin
                status_nxt = STAT_FULL;
              end else begin
                t_nxt           = SW'(count_r);
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_APPEND;
                iss_key_nxt     = ring_ne_r ? head_r : SW'(count_r);
                iss_val_nxt     = SW'(count_r);
                state_nxt       = S_WACT;
              end
            end
            MODE_TICK: begin
              if (ring_ne_r) begin
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_TICK;
                iss_ctl_nxt.flag  = cur_vld_r;
                iss_key_nxt     = head_r;
                iss_val_nxt     = cur_r;
                state_nxt       = S_WACT;
              end
            end
            MODE_BLOCK, MODE_WAKE: begin
              if (idx_ok) begin
                t_nxt           = in_slot;
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_PROBE;
                iss_key_nxt     = in_slot;
                state_nxt       = S_WPROBE;
              end
            end
            MODE_EXIT: begin
              if (cur_vld_r) begin
                t_nxt           = cur_r;
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_PROBE;
                iss_key_nxt     = cur_r;
                state_nxt       = S_WPROBE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_WPROBE: begin
        if (ret_ctl.valid) begin
          pst_nxt   = ret_ctl.rd_state;
          plink_nxt = ret_link;
          state_nxt = S_DONE;
          case (mode_r)
            MODE_BLOCK: begin
              if ((ret_ctl.rd_state == ST_READY) || (ret_ctl.rd_state == ST_RUNNING)) begin
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_UNLINK;
                iss_ctl_nxt.ns    = ST_BLOCKED;
                iss_key_nxt     = t_r;
                iss_val_nxt     = ret_link;
                state_nxt       = S_WACT;
              end
            end
            MODE_WAKE: begin
              if (ret_ctl.rd_state == ST_BLOCKED) begin
                iss_ctl_nxt.valid = 1'b1;
                iss_ctl_nxt.cmd   = CMD_APPEND;
                iss_key_nxt     = ring_ne_r ? head_r : t_r;
                iss_val_nxt     = t_r;
                state_nxt       = S_WACT;
              end
            end
            default: begin
              // exit: a blocked current slot is outside the ring and has no
              // predecessor, so the same unlink just frees it
              iss_ctl_nxt.valid = 1'b1;
              iss_ctl_nxt.cmd   = CMD_UNLINK;
              iss_ctl_nxt.ns    = ST_UNUSED;
              iss_key_nxt     = t_r;
              iss_val_nxt     = ret_link;
              state_nxt       = S_WACT;
            end
          endcase
        end
      end

      S_WACT: begin
        if (ret_ctl.valid) begin
          status_nxt = STAT_OK;
          state_nxt  = S_DONE;
          case (mode_r)
            MODE_CREATE: begin
              count_nxt = count_r + CW'(1);
              if (!ring_ne_r) begin
                head_nxt    = t_r;
                ring_ne_nxt = 1'b1;
              end
            end
            MODE_WAKE: begin
              if (!ring_ne_r) begin
                head_nxt    = t_r;
                ring_ne_nxt = 1'b1;
              end
            end
            MODE_TICK: begin
              cur_nxt     = head_r;
              cur_vld_nxt = 1'b1;
              head_nxt    = ret_link;
            end
            MODE_BLOCK: begin
              if (head_r == t_r) head_nxt = plink_r;
              if (plink_r == t_r) ring_ne_nxt = 1'b0;
            end
            default: begin
              if (pst_in_ring) begin
                if (head_r == t_r) head_nxt = plink_r;
                if (plink_r == t_r) ring_ne_nxt = 1'b0;
              end
              cur_vld_nxt = 1'b0;
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {1'b0, status_r, res_vld, res_task};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      ring_ne_r <= 1'b0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      count_r   <= '0;
      iss_ctl_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      ring_ne_r <= ring_ne_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      count_r   <= count_nxt;
      iss_ctl_r <= iss_ctl_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    status_r   <= status_nxt;
    t_r        <= t_nxt;
    pst_r      <= pst_nxt;
    plink_r    <= plink_nxt;
    iss_key_r  <= iss_key_nxt;
    iss_val_r  <= iss_val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // at most one token in the cell row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  // a token only comes back while the sequencer waits for it
  a_ret_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ret_ctl.valid |-> (state_r == S_WPROBE || state_r == S_WACT))
    else $error("token returned while not waiting");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("created count beyond pool size");

  // a completed exit leaves no current task
  a_exit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && mode_r == MODE_EXIT && status_r == STAT_OK) |-> !cur_vld_r)
    else $error("current task still valid after exit");

endmodule

[sv/rrq_cell.sv]
// ---------------------------------------------------------------------------
// rrq_cell - one task slot of the ready queue
// Holds the slot state and its ring link, acts on the token passing by and
// hands the token on to the next cell through a register.
// ---------------------------------------------------------------------------
module rrq_cell #(
  parameter int SW      = 4,
  parameter int CELL_ID = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrq_pkg::tok_ctl_t  ctl_i,
  input  logic [SW-1:0]      key_i,
  input  logic [SW-1:0]      val_i,
  input  logic [SW-1:0]      link_i,
  output rrq_pkg::tok_ctl_t  ctl_o,
  output logic [SW-1:0]      key_o,
  output logic [SW-1:0]      val_o,
  output logic [SW-1:0]      link_o
);
  import rrq_pkg::*;

  localparam logic [SW-1:0] MY_ID = SW'(CELL_ID);

  sstate_t       state_r, state_nxt;
  logic [SW-1:0] link_r, link_nxt;
  tok_ctl_t      ctl_r, ctl_nxt;
  logic [SW-1:0] key_r, val_r, rdl_r, rdl_nxt;

  logic hit_key, hit_val, in_ring, pred_hit;

  assign hit_key  = (key_i == MY_ID);
  assign hit_val  = (val_i == MY_ID);
  assign in_ring  = (state_r == ST_READY) || (state_r == ST_RUNNING);
  // this slot is in the ring and links to slot key
  assign pred_hit = in_ring && (link_r == key_i) && !hit_key;

  always_comb begin
    state_nxt = state_r;
    link_nxt  = link_r;
    ctl_nxt   = ctl_i;
    rdl_nxt   = link_i;
    if (ctl_i.valid) begin
      case (ctl_i.cmd)
        CMD_PROBE: begin
          if (hit_key) begin
            ctl_nxt.rd_state = state_r;
            rdl_nxt          = link_r;
          end
        end
        CMD_APPEND: begin
          if (hit_val) begin
            state_nxt = ST_READY;
            link_nxt  = key_i;
          end else if (in_ring && (link_r == key_i)) begin
            link_nxt = val_i;
          end
        end
        CMD_TICK: begin
          if (hit_key) begin
            state_nxt = ST_RUNNING;
            rdl_nxt   = link_r;
          end else if (ctl_i.flag && hit_val && (state_r == ST_RUNNING)) begin
            state_nxt = ST_READY;
          end
        end
        CMD_UNLINK: begin
          if (hit_key) begin
            state_nxt = ctl_i.ns;
          end else if (pred_hit) begin
            link_nxt = val_i;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_UNUSED;
      ctl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
    key_r  <= key_i;
    val_r  <= val_i;
    rdl_r  <= rdl_nxt;
  end

  assign ctl_o  = ctl_r;
  assign key_o  = key_r;
  assign val_o  = val_r;
  assign link_o = rdl_r;

endmodule

[dv/round_robin_ready_queue_test.sv]
// ---------------------------------------------------------------------------
// round_robin_ready_queue_test - self-checking bench for the task scheduler
// Sends a short list of directed requests, then a long run of random, mostly
// well-formed requests. The early directed ones carry fixed expected results,
// a scheduler model predicts the rest; each is compared field by field in order.
// ---------------------------------------------------------------------------
module round_robin_ready_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrq_pkg::*;

  localparam int MAX_TASKS     = 16;
  localparam int RAND_REQUESTS = 1976;
  localparam int DRAIN_CYCLES  = 2 * MAX_TASKS + 8;
  localparam int PRINT_LIMIT   = 40;

  // modes with no meaning; the block must ignore them
  localparam mode_t MODE_UNDEF_LO = 3'd5;
  localparam mode_t MODE_UNDEF_HI = 3'd7;

  // same bit order as out_tdata[6:0]
  typedef struct packed {
    status_t    status;
    logic       slot_valid;
    logic [3:0] slot;
  } sched_result_t;

  typedef struct {
    mode_t         m;
    logic [3:0]    idx;
    bit            typed;
    sched_result_t want;
  } req_plan_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;   // [2:0] mode, [6:3] task_index
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;       // [3:0] result_task, [4] result_valid,
                                        // [6:5] status

  round_robin_ready_queue #(
    .MAX_TASKS(MAX_TASKS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // scheduler state as the bench sees it
  sstate_t     slot_st [MAX_TASKS];
  int unsigned link_to [MAX_TASKS];
  int unsigned ring_head;
  bit          ring_live;
  int unsigned cur_slot;
  bit          cur_live;
  int unsigned n_created;

  sched_result_t expected_results[$];
  int            errors = 0;
  int            results_seen = 0;
  int            in_idle_pct = 14;

  function automatic bit in_ring(int unsigned s);
    return slot_st[s] == ST_READY || slot_st[s] == ST_RUNNING;
  endfunction

  function automatic void ring_link_in(int unsigned t);
    int unsigned tail;
    if (!ring_live) begin
      ring_head  = t;
      link_to[t] = t;
      ring_live  = 1'b1;
    end else begin
      tail = ring_head;
      for (int n = 0; n < MAX_TASKS && link_to[tail] != ring_head; n++)
        tail = link_to[tail];
      link_to[tail] = t;
      link_to[t]    = ring_head;
    end
  endfunction

  function automatic void ring_unlink(int unsigned t);
    int unsigned prev;
    if (!ring_live) return;
    if (link_to[t] == t) begin
      if (ring_head == t) ring_live = 1'b0;
      return;
    end
    prev = ring_head;
    for (int n = 0; n < MAX_TASKS; n++) begin
      if (link_to[prev] == t) break;
      prev = link_to[prev];
      if (prev == ring_head) return;
    end
    if (link_to[prev] != t) return;
    link_to[prev] = link_to[t];
    if (ring_head == t) ring_head = link_to[t];
  endfunction

  function automatic sched_result_t schedule_step(mode_t m, logic [3:0] idx);
    sched_result_t r;
    status_t       st;
    bit            made;
    int unsigned   made_slot;
    int unsigned   t;
    st        = STAT_IGNORED;
    made      = 1'b0;
    made_slot = 0;
    t         = idx;
    case (m)
      MODE_CREATE: begin
        if (n_created >= MAX_TASKS) begin
          st = STAT_FULL;
        end else begin
          made_slot = n_created;
          n_created++;
          slot_st[made_slot] = ST_READY;
          ring_link_in(made_slot);
          made = 1'b1;
          st   = STAT_OK;
        end
      end
      MODE_TICK: begin
        if (ring_live) begin
          // a blocked current task keeps its state
          if (cur_live && slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
          cur_slot  = ring_head;
          cur_live  = 1'b1;
          ring_head = link_to[ring_head];
          slot_st[cur_slot] = ST_RUNNING;
          st = STAT_OK;
        end
      end
      MODE_BLOCK: begin
        if (t < MAX_TASKS && in_ring(t)) begin
          ring_unlink(t);
          slot_st[t] = ST_BLOCKED;
          st = STAT_OK;
        end
      end
      MODE_WAKE: begin
        if (t < MAX_TASKS && slot_st[t] == ST_BLOCKED) begin
          slot_st[t] = ST_READY;
          ring_link_in(t);
          st = STAT_OK;
        end
      end
      MODE_EXIT: begin
        if (cur_live) begin
          if (in_ring(cur_slot)) ring_unlink(cur_slot);
          slot_st[cur_slot] = ST_UNUSED;
          cur_live = 1'b0;
          st = STAT_OK;
        end
      end
      default: ;
    endcase
    r.status = st;
    if (m == MODE_CREATE) begin
      r.slot_valid = made;
      r.slot       = made ? 4'(made_slot) : 4'd0;
    end else begin
      r.slot_valid = cur_live;
      r.slot       = cur_live ? 4'(cur_slot) : 4'd0;
    end
    return r;
  endfunction

  // slot in the wanted state most of the time, any index otherwise
  function automatic logic [3:0] pick_slot(bit want_blocked);
    int unsigned pool[$];
    for (int s = 0; s < int'(n_created); s++) begin
      if (want_blocked ? slot_st[s] == ST_BLOCKED : in_ring(s)) pool.push_back(s);
    end
    if (pool.size() != 0 && $urandom_range(0, 99) < 85)
      return 4'(pool[$urandom_range(0, pool.size() - 1)]);
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic int live_slots();
    int cnt;
    cnt = 0;
    for (int s = 0; s < int'(n_created); s++) begin
      if (slot_st[s] != ST_UNUSED) cnt++;
    end
    return cnt;
  endfunction

  function automatic req_plan_t plan(mode_t m, logic [3:0] idx, bit typed,
                                     logic [3:0] slot, logic v, status_t st);
    req_plan_t p;
    p.m     = m;
    p.idx   = idx;
    p.typed = typed;
    p.want  = '{status: st, slot_valid: v, slot: slot};
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(logic [6:0] d);
    sched_result_t got;
    sched_result_t want;
    got = d;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", d));
    end else begin
      want = expected_results.pop_front();
      if (got.slot !== want.slot)
        report_mismatch($sformatf("result_task %0d, want %0d", got.slot, want.slot));
      if (got.slot_valid !== want.slot_valid)
        report_mismatch($sformatf("result_valid %b, want %b", got.slot_valid,
                                  want.slot_valid));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    end
  endtask

  // holds the request until accepted, then books its expected result
  task automatic send_request(mode_t m, logic [3:0] idx, bit typed, sched_result_t want,
                              output status_t st);
    sched_result_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {1'b0, idx, m};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = schedule_step(m, idx);
    expected_results.push_back(typed ? want : r);
    st = r.status;
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin
    int stall_left;
    bit held;
    int pct;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result(out_tdata[6:0]);
      pct = (results_seen >= 800 && results_seen < 1100) ? 0 : 14;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!held && results_seen >= 300) begin
        held       = 1'b1;
        stall_left = 250;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  initial begin
    req_plan_t  rows[$];
    status_t    st;
    mode_t      m;
    logic [3:0] idx;
    int unsigned r;
    int         sent;

    for (int s = 0; s < MAX_TASKS; s++) begin
      slot_st[s] = ST_UNUSED;
      link_to[s] = 0;
    end
    ring_head = 0;
    ring_live = 1'b0;
    cur_slot  = 0;
    cur_live  = 1'b0;
    n_created = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty scheduler, then one task through block and exit, then a small ring
    rows.push_back(plan(MODE_TICK,     4'd0,  1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_EXIT,     4'd0,  1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_BLOCK,    4'd15, 1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_WAKE,     4'd0,  1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_UNDEF_LO, 4'd10, 1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_UNDEF_HI, 4'd5,  1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_CREATE,   4'd15, 1, 4'd0, 1'b1, STAT_OK));
    rows.push_back(plan(MODE_TICK,     4'd0,  1, 4'd0, 1'b1, STAT_OK));
    rows.push_back(plan(MODE_BLOCK,    4'd0,  1, 4'd0, 1'b1, STAT_OK));
    rows.push_back(plan(MODE_TICK,     4'd0,  1, 4'd0, 1'b1, STAT_IGNORED));
    rows.push_back(plan(MODE_EXIT,     4'd0,  1, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_WAKE,     4'd0,  1, 4'd0, 1'b0, STAT_IGNORED));
    rows.push_back(plan(MODE_CREATE,   4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_CREATE,   4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_CREATE,   4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_TICK,     4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_TICK,     4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_BLOCK,    4'd3,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_WAKE,     4'd3,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_BLOCK,    4'd2,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_TICK,     4'd0,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_WAKE,     4'd15, 0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_BLOCK,    4'd1,  0, 4'd0, 1'b0, STAT_OK));
    rows.push_back(plan(MODE_EXIT,     4'd0,  0, 4'd0, 1'b0, STAT_OK));

    foreach (rows[i]) send_request(rows[i].m, rows[i].idx, rows[i].typed, rows[i].want, st);

    sent = 0;
    while (sent < RAND_REQUESTS) begin
      in_idle_pct = (sent >= 500 && sent < 800) ? 0 : 14;
      if (sent == 1000) begin
        // let the scheduler run dry before going on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end
      r   = $urandom_range(0, 999);
      idx = 4'($urandom_range(0, 15));
      if (r < 80) begin
        m = mode_t'($urandom_range(0, 7));
      end else if (r < 150) begin
        m = MODE_CREATE;
      end else if (r < 156) begin
        m = MODE_EXIT;
      end else if (r < 560) begin
        m = MODE_TICK;
      end else if (r < 780) begin
        m   = MODE_BLOCK;
        idx = pick_slot(1'b0);
      end else begin
        m   = MODE_WAKE;
        idx = pick_slot(1'b1);
      end
      // slots are never reused, so keep a few alive
      if (m == MODE_EXIT && live_slots() <= 4) m = MODE_TICK;
      send_request(m, idx, 1'b0, '0, st);
      sent++;
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(12_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
